/* sv/hvn_pkg.sv */
package hvn_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DivBits  = 8;

  localparam logic [31:0] NoiseSalt = 32'h94d0_49bb;
  localparam logic [31:0] HashMulX  = 32'h9e37_79b9;
  localparam logic [31:0] HashMulY  = 32'h85eb_ca6b;
  localparam logic [31:0] HashMix   = 32'h7feb_352d;
  localparam logic [5:0]  CoverageMax = 6'd40;

  // Register byte addresses
  localparam logic [3:0] AddrSeed     = 4'h0;
  localparam logic [3:0] AddrCellSize = 4'h4;
  localparam logic [3:0] AddrCoverage = 4'h8;

  typedef struct packed {
    logic [31:0]        key;
    logic [DivBits-1:0] div;
    logic [5:0]         cov;
  } hvn_cfg_t;

  typedef struct packed {
    logic [DivBits-1:0] rem;
    logic               q;
  } hvn_step_t;

  // One restoring division step: bring in one dividend bit, subtract if it fits.
  function automatic hvn_step_t div_step(input logic [DivBits-1:0] rem,
                                         input logic din,
                                         input logic [DivBits-1:0] div);
    logic [DivBits:0] t;
    logic [DivBits:0] s;
    hvn_step_t        r;
    t = {rem, din};
    s = t - {1'b0, div};
    r.q   = (t >= {1'b0, div});
    r.rem = r.q ? s[DivBits-1:0] : t[DivBits-1:0];
    return r;
  endfunction

  // Finish smoothstep: f2 * (3 - 2f) in Q0.16, saturated.
  function automatic logic [15:0] ease_finish(input logic [15:0] f2,
                                              input logic [15:0] f);
    logic [17:0] g;
    logic [33:0] p;
    g = 18'd196608 - {1'b0, f, 1'b0};
    p = {18'd0, f2} * {16'd0, g};
    return (p[33:32] != 2'd0) ? 16'hffff : p[31:16];
  endfunction

endpackage

/* sv/hashed_value_noise_2d_core.sv */
// Channel    | Dir | Signals                         | Contents
// s_axis     | in  | tvalid/tready/tdata             | x_coord, y_coord
// m_axis     | out | tvalid/tready/tdata/tuser        | noise_value, below_coverage
// apb        | in  | psel/penable/pwrite/paddr/...    | seed, cell_size, coverage_percent
//
// One coordinate per cycle, sustained, while m_axis is not stalled. The restoring divider
// takes one quotient bit per stage for the cell index and the Q0.16 fraction, then
// the hash, ease and blend stages follow.
// Reset (rst_ni, async low) clears all valid bits and loads the register defaults.
// A stall on m_axis freezes the whole pipe; s_axis_tready drops with it.
module hashed_value_noise_2d_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [COORD_BITS-1:0] x_coord, [2*COORD_BITS-1:COORD_BITS] y_coord, zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [15:0] noise_value
  output logic [15:0]                            m_axis_tdata,
  // [0] below_coverage
  output logic                                   m_axis_tuser,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import hvn_pkg::*;

  localparam int unsigned DW = COORD_BITS + FracBits;

  hvn_cfg_t                  cfg;
  logic                      adv;
  logic [1:0][COORD_BITS-1:0] coord;
  logic                      dv_valid;
  logic [1:0][DW-1:0]        quot;

  hvn_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Advance the whole pipe whenever the output slot is free or being taken
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign coord[0] = s_axis_tdata[COORD_BITS-1:0];
  assign coord[1] = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  hvn_divider #(.CoordBits(COORD_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(s_axis_tvalid),
    .coord_i(coord),
    .div_i  (cfg.div),
    .valid_o(dv_valid),
    .quot_o (quot)
  );

  // Stage 1: corner products and squared fractions
  logic [31:0] cx, cy, cx1, cy1;
  logic [31:0] mx0_d, mx1_d, my0_d, my1_d;
  logic [31:0] fxx, fyy;
  logic [31:0] mx0_q, mx1_q, my0_q, my1_q;
  logic [15:0] fx_q, fy_q, f2x_q, f2y_q;
  logic        s1_valid_q;

  assign cx    = 32'(quot[0][DW-1:FracBits]);
  assign cy    = 32'(quot[1][DW-1:FracBits]);
  assign cx1   = cx + 32'd1;   // last cell wraps modulo 2^32
  assign cy1   = cy + 32'd1;
  assign mx0_d = cx * HashMulX;
  assign mx1_d = cx1 * HashMulX;
  assign my0_d = cy * HashMulY;
  assign my1_d = cy1 * HashMulY;
  assign fxx   = quot[0][FracBits-1:0] * quot[0][FracBits-1:0];
  assign fyy   = quot[1][FracBits-1:0] * quot[1][FracBits-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx0_q <= mx0_d;
      mx1_q <= mx1_d;
      my0_q <= my0_d;
      my1_q <= my1_d;
      fx_q  <= quot[0][FracBits-1:0];
      fy_q  <= quot[1][FracBits-1:0];
      f2x_q <= fxx[31:16];
      f2y_q <= fyy[31:16];
    end
  end

  // Stage 2: key mix and hash multiply for the four corners, finish ease.
  // Corner order: 00, 10, 01, 11.
  logic [3:0][31:0] v_d, m_d;
  logic [3:0][31:0] m_q;
  logic [15:0]      wx_q, wy_q;
  logic             s2_valid_q;

  assign v_d[0] = cfg.key ^ mx0_q ^ my0_q;
  assign v_d[1] = cfg.key ^ mx1_q ^ my0_q;
  assign v_d[2] = cfg.key ^ mx0_q ^ my1_q;
  assign v_d[3] = cfg.key ^ mx1_q ^ my1_q;

  for (genvar c = 0; c < 4; c++) begin : g_mix
    logic [31:0] vs;
    assign vs     = v_d[c] ^ (v_d[c] >> 16);
    assign m_d[c] = vs * HashMix;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q  <= m_d;
      wx_q <= ease_finish(f2x_q, fx_q);
      wy_q <= ease_finish(f2y_q, fy_q);
    end
  end

  // Stage 3: final xorshift, blend rows in x
  logic [3:0][15:0] h;
  logic [15:0]      top_d, bot_d;
  logic [15:0]      top_q, bot_q, wy3_q;
  logic             s3_valid_q;

  for (genvar c = 0; c < 4; c++) begin : g_fin
    logic [31:0] hf;
    assign hf   = m_q[c] ^ (m_q[c] >> 15);
    assign h[c] = hf[15:0];
  end

  hvn_lerp u_lerp_top (.a_i(h[0]), .b_i(h[1]), .w_i(wx_q), .y_o(top_d));
  hvn_lerp u_lerp_bot (.a_i(h[2]), .b_i(h[3]), .w_i(wx_q), .y_o(bot_d));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      top_q <= top_d;
      bot_q <= bot_d;
      wy3_q <= wy_q;
    end
  end

  // Stage 4: blend across rows in y
  logic [15:0] noise_d, noise_q;
  logic        s4_valid_q;

  hvn_lerp u_lerp_y (.a_i(top_q), .b_i(bot_q), .w_i(wy3_q), .y_o(noise_d));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      noise_q <= noise_d;
    end
  end

  // Stage 5: output register with threshold flag
  logic [22:0] lhs, rhs;
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        out_user_q;

  assign lhs = 23'(noise_q) * 23'd100;
  assign rhs = 23'(cfg.cov) * 23'd65535;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= noise_q;
      out_user_q <= (lhs < rhs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= dv_valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // A blend never leaves the range of its two corners
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> ((top_d >= h[0] || top_d >= h[1]) &&
                    (top_d <= h[0] || top_d <= h[1])))
    else $error("top row blend out of corner range");

  // Hold the stage 1, stage 4 and output valid bits while the pipe is stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s1_valid_q) && $stable(s4_valid_q) && $stable(out_valid_q)))
    else $error("pipe moved during stall");

  // Output only drops after the consumer took the transfer
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(m_axis_tready))
    else $error("result dropped without transfer");

endmodule

/* sv/hvn_cfg.sv */
module hvn_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output hvn_pkg::hvn_cfg_t cfg_o
);
  import hvn_pkg::*;

  logic [31:0]        seed_q;
  logic [DivBits-1:0] cell_q;
  logic [5:0]         cov_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 32'd1;
      cell_q <= 8'd6;
      cov_q  <= 6'd10;
    end else if (wr_en) begin
      case (paddr)
        AddrSeed:     seed_q <= pwdata;
        AddrCellSize: cell_q <= pwdata[DivBits-1:0];
        AddrCoverage: cov_q  <= pwdata[5:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrSeed:     prdata = seed_q;
      AddrCellSize: prdata = {24'd0, cell_q};
      AddrCoverage: prdata = {26'd0, cov_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Zero cell size acts as one; coverage saturates at forty
  assign cfg_o.key = seed_q ^ NoiseSalt;
  assign cfg_o.div = (cell_q == '0) ? 8'd1 : cell_q;
  assign cfg_o.cov = (cov_q > CoverageMax) ? CoverageMax : cov_q;

endmodule

/* sv/hvn_divider.sv */
module hvn_divider #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        adv_i,
  input  logic                                        valid_i,
  input  logic [1:0][CoordBits-1:0]                   coord_i,
  input  logic [hvn_pkg::DivBits-1:0]                 div_i,
  output logic                                        valid_o,
  output logic [1:0][CoordBits+hvn_pkg::FracBits-1:0] quot_o
);
  import hvn_pkg::*;

  localparam int unsigned DW = CoordBits + FracBits;

  logic [DW-1:0]                       valid_d;
  logic [DW-1:0]                       valid_q;
  logic [DW-1:0][1:0][DivBits-1:0]     rem_d;
  logic [DW-1:0][1:0][DivBits-1:0]     rem_q;
  logic [DW-1:0][1:0][DW-1:0]          z_d;
  logic [DW-1:0][1:0][DW-1:0]          z_q;

  // Dividend is coord followed by sixteen zero bits: the quotient holds the
  // cell index above the Q0.16 fraction.
  for (genvar k = 0; k < DW; k++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DivBits-1:0] rem_in;
      logic [DW-1:0]      z_in;
      hvn_step_t          st;
      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign z_in   = {coord_i[l], {FracBits{1'b0}}};
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign z_in   = z_q[k-1][l];
      end
      assign st          = div_step(rem_in, z_in[DW-1], div_i);
      assign rem_d[k][l] = st.rem;
      assign z_d[k][l]   = {z_in[DW-2:0], st.q};
    end

    if (k == 0) begin : g_v0
      assign valid_d[k] = valid_i;
    end else begin : g_vn
      assign valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q <= rem_d;
      z_q   <= z_d;
    end
  end

  assign valid_o = valid_q[DW-1];
  assign quot_o  = z_q[DW-1];

endmodule

/* sv/hvn_lerp.sv */
module hvn_lerp (
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  input  logic [15:0] w_i,
  output logic [15:0] y_o
);
  logic [16:0] wa;
  logic [32:0] pa;
  logic [32:0] pb;
  logic [32:0] sum;

  assign wa  = 17'd65536 - {1'b0, w_i};
  assign pa  = {17'd0, a_i} * {16'd0, wa};
  assign pb  = {17'd0, b_i} * {17'd0, w_i};
  assign sum = pa + pb;
  assign y_o = sum[31:16];

endmodule

/* tb/hashed_value_noise_2d_core_tb.sv */
module hashed_value_noise_2d_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hvn_pkg::*;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned Latency = CoordBits + 16 + 5;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [15:0] noise;
    logic        below;
  } sample_t;

  // One row of the directed table: coordinates and, where known, the sample.
  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    bit          known;
    sample_t     want;
  } coord_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the configuration registers.
  logic [31:0] seed_q = 32'd1;
  logic [7:0]  cell_q = 8'd6;
  logic [5:0]  cov_q = 6'd10;

  sample_t     pending_samples[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned results_seen = 0;
  bit          sink_hold = 1'b0;
  bit          stall_mode = 1'b1;
  bit          stim_done = 1'b0;

  hashed_value_noise_2d_core #(.COORD_BITS(CoordBits)) dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] corner_hash(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] key);
    logic [31:0] v;
    v = key ^ (cx * HashMulX) ^ (cy * HashMulY);
    v ^= v >> 16;
    v = v * HashMix;
    return v ^ (v >> 15);
  endfunction

  function automatic logic [15:0] eased_weight(logic [15:0] rem, logic [7:0] div);
    logic [63:0] f, f2, t;
    f  = ({48'd0, rem} << 16) / div;
    f2 = (f * f) >> 16;
    t  = (f2 * (64'd196608 - 2 * f)) >> 16;
    return (t > 64'hffff) ? 16'hffff : t[15:0];
  endfunction

  function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] w);
    return (a * (64'd65536 - w) + b * w) >> 16;
  endfunction

  function automatic sample_t noise_at(logic [15:0] x, logic [15:0] y);
    logic [7:0]  div;
    logic [31:0] cx, cy, key;
    logic [63:0] wx, wy, h00, h10, h01, h11, top, bottom, cov;
    sample_t     s;
    div = (cell_q == 0) ? 8'd1 : cell_q;
    cx  = x / div;
    cy  = y / div;
    wx  = eased_weight(x % div, div);
    wy  = eased_weight(y % div, div);
    key = seed_q ^ NoiseSalt;
    h00 = corner_hash(cx, cy, key) & 32'hffff;
    h10 = corner_hash(cx + 1, cy, key) & 32'hffff;
    h01 = corner_hash(cx, cy + 1, key) & 32'hffff;
    h11 = corner_hash(cx + 1, cy + 1, key) & 32'hffff;
    top    = blend(h00, h10, wx);
    bottom = blend(h01, h11, wx);
    s.noise = 16'(blend(top, bottom, wy));
    cov = (cov_q > CoverageMax) ? CoverageMax : cov_q;
    s.below = (s.noise * 64'd100 < cov * 64'd65535);
    return s;
  endfunction

  // Random gap: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (addr)
      AddrSeed:     seed_q = value;
      AddrCellSize: cell_q = value[7:0];
      AddrCoverage: cov_q  = value[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offer one coordinate pair and hold it until the transfer happens.
  task automatic send_coord(logic [15:0] x, logic [15:0] y, bit known, sample_t want,
                            bit gaps);
    int unsigned g;
    sample_t     predicted;
    g = gaps ? gap_len() : 0;
    repeat (g) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = noise_at(x, y);
    if (known && predicted != want) begin
      $error("table row (%0d,%0d): noise exp %0d act %0d", x, y, want.noise,
             predicted.noise);
      mismatches++;
    end
    pending_samples.insert(pending_samples.size(), known ? want : predicted);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Receiver: random stalls, checks each transfer against the oldest expectation.
  initial begin : sink
    int unsigned g;
    forever begin
      @(negedge clk_i);
      if (sink_hold) m_axis_tready <= 1'b0;
      else if (!stall_mode) m_axis_tready <= 1'b1;
      else begin
        g = gap_len();
        if (g == 0) m_axis_tready <= 1'b1;
        else begin
          m_axis_tready <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    sample_t oldest;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_samples.size() == 0) begin
        $error("unexpected result noise %0d", m_axis_tdata);
        mismatches++;
      end else begin
        oldest = pending_samples.pop_front();
        if (m_axis_tdata !== oldest.noise) begin
          $error("noise_value: expected %0d actual %0d", oldest.noise, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== oldest.below) begin
          $error("below_coverage: expected %0b actual %0b", oldest.below, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!stim_done && psel))
      idle_cycles <= 0;
    else if (rst_ni && !sink_hold)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  coord_row_t directed[] = '{
    '{16'd0,     16'd0,     1'b0, '0},
    '{16'hffff,  16'hffff,  1'b0, '0},
    '{16'hffff,  16'd0,     1'b0, '0},
    '{16'd0,     16'hffff,  1'b0, '0},
    '{16'd5,     16'd5,     1'b0, '0},
    '{16'd6,     16'd6,     1'b0, '0},
    '{16'h5555,  16'haaaa,  1'b0, '0},
    '{16'haaaa,  16'h5555,  1'b0, '0},
    '{16'd3,     16'd1,     1'b0, '0},
    '{16'd65534, 16'd1,     1'b0, '0}
  };

  task automatic random_phase(int unsigned count);
    logic [15:0] x, y;
    sample_t     none;
    none = '0;
    for (int unsigned i = 0; i < count; i++) begin
      x = ($urandom_range(3) == 0) ? 16'($urandom_range(16)) : 16'($urandom);
      y = ($urandom_range(3) == 0) ? 16'(16'hffff - $urandom_range(16)) : 16'($urandom);
      send_coord(x, y, 1'b0, none, 1'b1);
    end
    drain();
  endtask

  initial begin : stimulus
    sample_t none;
    none = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed sweep at reset configuration, then with a zero cell size, then with cell size 255.
    foreach (directed[i])
      send_coord(directed[i].x, directed[i].y, directed[i].known, directed[i].want, 1'b0);
    drain();
    write_reg(AddrCellSize, 32'd0);
    write_reg(AddrCoverage, 32'd63);
    foreach (directed[i])
      send_coord(directed[i].x, directed[i].y, 1'b0, none, 1'b0);
    drain();
    write_reg(AddrSeed, 32'hffff_ffff);
    write_reg(AddrCellSize, 32'd255);
    write_reg(AddrCoverage, 32'd0);
    foreach (directed[i])
      send_coord(directed[i].x, directed[i].y, 1'b0, none, 1'b0);
    drain();

    // Back pressure: hold the sink off long enough to fill the pipe.
    sink_hold = 1'b1;
    fork
      begin
        repeat (150) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      random_phase(60);
    join

    write_reg(AddrSeed, $urandom);
    write_reg(AddrCellSize, 32'd1);
    write_reg(AddrCoverage, 32'd40);
    random_phase(90);

    stall_mode = 1'b0;
    write_reg(AddrSeed, 32'd0);
    write_reg(AddrCellSize, $urandom_range(254, 2));
    write_reg(AddrCoverage, $urandom_range(40));
    random_phase(60);
    stall_mode = 1'b1;

    for (int p = 0; p < 3; p++) begin
      write_reg(AddrSeed, $urandom);
      write_reg(AddrCellSize, $urandom_range(255));
      write_reg(AddrCoverage, $urandom_range(63));
      random_phase(70);
    end

    stim_done = 1'b1;
    if (mismatches == 0 && pending_samples.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
sv/hvn_pkg.sv
sv/hvn_cfg.sv
sv/hvn_divider.sv
sv/hvn_lerp.sv
sv/hashed_value_noise_2d_core.sv
tb/hashed_value_noise_2d_core_tb.sv
